/* rtl/core/ppi_pkg.sv */
// ----------------------------------------------------------------------------
// Plane-plane intersection package
// Widths, codes and payload types shared by the intersection pipeline.
// ----------------------------------------------------------------------------
package ppi_pkg;

	localparam int COORD_W   = 32;
	localparam int THR_W     = 16;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int U_W       = PROD_W + 1;
	localparam int UM_W      = PROD_W;
	localparam int A_W       = UM_W - FRAC_W;
	localparam int SUM_W     = A_W + 2;
	localparam int D_W       = PROD_W + 2;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int DOT_W     = DIFF_W + COORD_W + 2;
	localparam int DL_W      = D_W / 2;
	localparam int DH_W      = D_W - DL_W;
	localparam int NUM_W     = D_W + COORD_W + 1;
	localparam int DIV_STEPS = COORD_W - 1;
	localparam int DIV_LAT   = DIV_STEPS + 3;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic [1:0] REL_DISJOINT   = 2'd0;
	localparam logic [1:0] REL_COINCIDENT = 2'd1;
	localparam logic [1:0] REL_LINE       = 2'd2;

	typedef enum logic [1:0] {
		AX_X,
		AX_Y,
		AX_Z
	} axis_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_point_x;
		logic signed [COORD_W-1:0] first_point_y;
		logic signed [COORD_W-1:0] first_point_z;
		logic signed [COORD_W-1:0] first_normal_x;
		logic signed [COORD_W-1:0] first_normal_y;
		logic signed [COORD_W-1:0] first_normal_z;
		logic signed [COORD_W-1:0] second_point_x;
		logic signed [COORD_W-1:0] second_point_y;
		logic signed [COORD_W-1:0] second_point_z;
		logic signed [COORD_W-1:0] second_normal_x;
		logic signed [COORD_W-1:0] second_normal_y;
		logic signed [COORD_W-1:0] second_normal_z;
	} ppi_in_t;

	typedef struct packed {
		logic [1:0]                relation;
		logic signed [COORD_W-1:0] line_point_x;
		logic signed [COORD_W-1:0] line_point_y;
		logic signed [COORD_W-1:0] line_point_z;
		logic signed [COORD_W-1:0] line_dir_x;
		logic signed [COORD_W-1:0] line_dir_y;
		logic signed [COORD_W-1:0] line_dir_z;
	} ppi_out_t;

	typedef struct packed {
		logic [1:0]                relation;
		axis_t                     axis;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
	} ppi_side_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] m1;
		logic signed [COORD_W-1:0] m2;
		logic                      flip;
	} ppi_coef_t;

	typedef struct packed {
		logic signed [D_W-1:0] d1;
		logic signed [D_W-1:0] d2;
		logic signed [U_W-1:0] den;
		logic                  zero;
		ppi_coef_t [1:0]       lane;
	} ppi_sel_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic signed [U_W-1:0]   den;
		logic                    flip;
		logic                    zero;
	} ppi_lane_t;

endpackage

/* rtl/core/ppi_if.sv */
// ----------------------------------------------------------------------------
// Plane-plane intersection channels
// Valid/ready channels for plane pairs and line results.
// ----------------------------------------------------------------------------
interface ppi_in_if import ppi_pkg::*; ();
	logic    valid;
	logic    ready;
	ppi_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface ppi_out_if import ppi_pkg::*; ();
	logic     valid;
	logic     ready;
	ppi_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/ppi_front.sv */
// ----------------------------------------------------------------------------
// Plane-plane intersection front end
// Products, cross product, plane offsets, parallel test and axis choice.
// ----------------------------------------------------------------------------
module ppi_front import ppi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  ppi_in_t          in_data,
	input  logic [THR_W-1:0] thr,
	output logic             out_valid,
	output ppi_sel_t         sel,
	output ppi_side_t        side
);

	logic signed [COORD_W-1:0] p1 [0:2];
	logic signed [COORD_W-1:0] p2 [0:2];
	logic signed [COORD_W-1:0] n1 [0:2];
	logic signed [COORD_W-1:0] n2 [0:2];
	logic signed [DIFF_W-1:0]  dp [0:2];

	logic signed [PROD_W-1:0]       pc_s1  [0:5];
	logic signed [PROD_W-1:0]       pd1_s1 [0:2];
	logic signed [PROD_W-1:0]       pd2_s1 [0:2];
	logic signed [DIFF_W+COORD_W-1:0] pt_s1 [0:2];
	logic signed [COORD_W-1:0]      n1_s1  [0:2];
	logic signed [COORD_W-1:0]      n2_s1  [0:2];

	logic signed [U_W-1:0]     u_s2   [0:2];
	logic signed [D_W-1:0]     d1_s2;
	logic signed [D_W-1:0]     d2_s2;
	logic signed [DOT_W-1:0]   dot_s2;
	logic signed [COORD_W-1:0] n1_s2  [0:2];
	logic signed [COORD_W-1:0] n2_s2  [0:2];

	logic [UM_W-1:0]  um [0:2];
	logic [A_W-1:0]   a  [0:2];
	logic [SUM_W-1:0] sum;
	logic [THR_W-1:0] thr_eff;
	logic             parallel;
	axis_t            axis;
	ppi_sel_t         sel_d;
	ppi_side_t        side_d;

	logic      v_s1, v_s2, v_s3;
	ppi_sel_t  sel_s3;
	ppi_side_t side_s3;

	function automatic logic signed [COORD_W-1:0] sat_dir(input logic neg,
			input logic [A_W-1:0] mag);
		logic [A_W-1:0] lim_p;
		logic [A_W-1:0] lim_n;
		lim_p = {{(A_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
		lim_n = lim_p + A_W'(1);
		if (!neg) begin
			return (mag > lim_p) ? COORD_MAX : mag[COORD_W-1:0];
		end
		return (mag > lim_n) ? COORD_MIN : -mag[COORD_W-1:0];
	endfunction

	always_comb begin
		p1[0] = in_data.first_point_x;
		p1[1] = in_data.first_point_y;
		p1[2] = in_data.first_point_z;
		n1[0] = in_data.first_normal_x;
		n1[1] = in_data.first_normal_y;
		n1[2] = in_data.first_normal_z;
		p2[0] = in_data.second_point_x;
		p2[1] = in_data.second_point_y;
		p2[2] = in_data.second_point_z;
		n2[0] = in_data.second_normal_x;
		n2[1] = in_data.second_normal_y;
		n2[2] = in_data.second_normal_z;
		for (int i = 0; i < 3; i++) begin
			dp[i] = DIFF_W'(p2[i]) - DIFF_W'(p1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s1[0] <= n1[1] * n2[2];
			pc_s1[1] <= n1[2] * n2[1];
			pc_s1[2] <= n1[2] * n2[0];
			pc_s1[3] <= n1[0] * n2[2];
			pc_s1[4] <= n1[0] * n2[1];
			pc_s1[5] <= n1[1] * n2[0];
			for (int i = 0; i < 3; i++) begin
				pd1_s1[i] <= n1[i] * p1[i];
				pd2_s1[i] <= n2[i] * p2[i];
				pt_s1[i]  <= n1[i] * dp[i];
				n1_s1[i]  <= n1[i];
				n2_s1[i]  <= n2[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u_s2[i]  <= U_W'(pc_s1[2*i]) - U_W'(pc_s1[2*i+1]);
				n1_s2[i] <= n1_s1[i];
				n2_s2[i] <= n2_s1[i];
			end
			d1_s2  <= D_W'(0) - D_W'(pd1_s1[0]) - D_W'(pd1_s1[1]) - D_W'(pd1_s1[2]);
			d2_s2  <= D_W'(0) - D_W'(pd2_s1[0]) - D_W'(pd2_s1[1]) - D_W'(pd2_s1[2]);
			dot_s2 <= DOT_W'(pt_s1[0]) + DOT_W'(pt_s1[1]) + DOT_W'(pt_s1[2]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			um[i] = u_s2[i][U_W-1] ? UM_W'(-u_s2[i]) : UM_W'(u_s2[i]);
			a[i]  = um[i][UM_W-1:FRAC_W];
		end
		sum      = SUM_W'(a[0]) + SUM_W'(a[1]) + SUM_W'(a[2]);
		thr_eff  = (thr == '0) ? THR_W'(1) : thr;
		parallel = sum < SUM_W'(thr_eff);

		priority if (a[0] > a[1] && a[0] > a[2]) begin
			axis = AX_X;
		end else if (a[1] > a[2]) begin
			axis = AX_Y;
		end else begin
			axis = AX_Z;
		end

		sel_d.d1   = d1_s2;
		sel_d.d2   = d2_s2;
		sel_d.zero = parallel;
		unique case (axis)
			AX_X: begin
				sel_d.den          = u_s2[0];
				sel_d.lane[0].m1   = n1_s2[2];
				sel_d.lane[0].m2   = n2_s2[2];
				sel_d.lane[0].flip = 1'b0;
				sel_d.lane[1].m1   = n1_s2[1];
				sel_d.lane[1].m2   = n2_s2[1];
				sel_d.lane[1].flip = 1'b1;
			end
			AX_Y: begin
				sel_d.den          = u_s2[1];
				sel_d.lane[0].m1   = n1_s2[2];
				sel_d.lane[0].m2   = n2_s2[2];
				sel_d.lane[0].flip = 1'b1;
				sel_d.lane[1].m1   = n1_s2[0];
				sel_d.lane[1].m2   = n2_s2[0];
				sel_d.lane[1].flip = 1'b0;
			end
			default: begin
				sel_d.den          = u_s2[2];
				sel_d.lane[0].m1   = n1_s2[1];
				sel_d.lane[0].m2   = n2_s2[1];
				sel_d.lane[0].flip = 1'b0;
				sel_d.lane[1].m1   = n1_s2[0];
				sel_d.lane[1].m2   = n2_s2[0];
				sel_d.lane[1].flip = 1'b1;
			end
		endcase

		side_d.axis  = axis;
		side_d.dir_x = sat_dir(u_s2[0][U_W-1], a[0]);
		side_d.dir_y = sat_dir(u_s2[1][U_W-1], a[1]);
		side_d.dir_z = sat_dir(u_s2[2][U_W-1], a[2]);
		if (!parallel) begin
			side_d.relation = REL_LINE;
		end else if (dot_s2 == '0) begin
			side_d.relation = REL_COINCIDENT;
		end else begin
			side_d.relation = REL_DISJOINT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s3  <= sel_d;
			side_s3 <= side_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign out_valid = v_s3;
	assign sel       = sel_s3;
	assign side      = side_s3;

endmodule

/* rtl/core/ppi_numer.sv */
// ----------------------------------------------------------------------------
// Plane-plane intersection numerators
// Split-operand products and the two line point numerators.
// ----------------------------------------------------------------------------
module ppi_numer import ppi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  ppi_sel_t  sel,
	input  ppi_side_t side_in,
	output logic      out_valid,
	output ppi_lane_t lane_a,
	output ppi_lane_t lane_b,
	output ppi_side_t side_out
);

	localparam int PH_W = DH_W + COORD_W;
	localparam int PL_W = DL_W + 1 + COORD_W;
	localparam int HI_W = PH_W + 1;
	localparam int LO_W = PL_W + 1;

	logic signed [DH_W-1:0] dh1, dh2;
	logic signed [DL_W:0]   dl1, dl2;

	logic signed [PH_W-1:0] ph1_s4 [0:1];
	logic signed [PH_W-1:0] ph2_s4 [0:1];
	logic signed [PL_W-1:0] pl1_s4 [0:1];
	logic signed [PL_W-1:0] pl2_s4 [0:1];
	logic signed [U_W-1:0]  den_s4;
	logic                   zero_s4;
	logic                   flip_s4 [0:1];
	ppi_side_t              side_s4;

	logic signed [HI_W-1:0] hi [0:1];
	logic signed [LO_W-1:0] lo [0:1];
	ppi_lane_t              lane_s5 [0:1];
	ppi_side_t              side_s5;
	logic                   v_s4, v_s5;

	assign dh1 = $signed(sel.d1[D_W-1:DL_W]);
	assign dh2 = $signed(sel.d2[D_W-1:DL_W]);
	assign dl1 = $signed({1'b0, sel.d1[DL_W-1:0]});
	assign dl2 = $signed({1'b0, sel.d2[DL_W-1:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < 2; g++) begin
				ph2_s4[g]  <= dh2 * sel.lane[g].m1;
				ph1_s4[g]  <= dh1 * sel.lane[g].m2;
				pl2_s4[g]  <= dl2 * sel.lane[g].m1;
				pl1_s4[g]  <= dl1 * sel.lane[g].m2;
				flip_s4[g] <= sel.lane[g].flip;
			end
			den_s4  <= sel.den;
			zero_s4 <= sel.zero;
			side_s4 <= side_in;
		end
	end

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			hi[g] = HI_W'(ph2_s4[g]) - HI_W'(ph1_s4[g]);
			lo[g] = LO_W'(pl2_s4[g]) - LO_W'(pl1_s4[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < 2; g++) begin
				lane_s5[g].num  <= (NUM_W'(hi[g]) <<< DL_W) + NUM_W'(lo[g]);
				lane_s5[g].den  <= den_s4;
				lane_s5[g].flip <= flip_s4[g];
				lane_s5[g].zero <= zero_s4;
			end
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
		end
	end

	assign out_valid = v_s5;
	assign lane_a    = lane_s5[0];
	assign lane_b    = lane_s5[1];
	assign side_out  = side_s5;

endmodule

/* rtl/core/ppi_div.sv */
// ----------------------------------------------------------------------------
// Plane-plane intersection divider
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module ppi_div import ppi_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  ppi_lane_t                 lane,
	output logic                      out_valid,
	output logic signed [COORD_W-1:0] quo
);

	logic [NUM_W-1:0]     magn_s0;
	logic [UM_W-1:0]      magd_s0;
	logic                 neg_s0, zero_s0;

	logic [NUM_W-1:0]     rem_s  [0:DIV_STEPS-1];
	logic [UM_W-1:0]      magd_s [0:DIV_STEPS-1];
	logic [DIV_STEPS-1:0] quo_s  [0:DIV_STEPS];
	logic                 neg_s  [0:DIV_STEPS];
	logic                 zero_s [0:DIV_STEPS];
	logic                 ovf_s  [0:DIV_STEPS];
	logic                 vld_s  [0:DIV_STEPS+2];

	logic [COORD_W-1:0]   q_ext;
	logic signed [COORD_W-1:0] quo_q;

	always_ff @(posedge clk) begin
		if (en) begin
			magn_s0 <= lane.num[NUM_W-1] ? NUM_W'(-lane.num) : NUM_W'(lane.num);
			magd_s0 <= lane.den[U_W-1] ? UM_W'(-lane.den) : UM_W'(lane.den);
			neg_s0  <= lane.num[NUM_W-1] ^ lane.den[U_W-1] ^ lane.flip;
			zero_s0 <= lane.zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= magn_s0;
			magd_s[0] <= magd_s0;
			ovf_s[0]  <= magn_s0 >= (NUM_W'(magd_s0) << DIV_STEPS);
			quo_s[0]  <= '0;
			neg_s[0]  <= neg_s0;
			zero_s[0] <= zero_s0;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [NUM_W-1:0] dsh;
		logic             take;

		assign dsh  = NUM_W'(magd_s[j]) << (DIV_STEPS - 1 - j);
		assign take = rem_s[j] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j+1]  <= quo_s[j] | (DIV_STEPS'(take) << (DIV_STEPS - 1 - j));
				neg_s[j+1]  <= neg_s[j];
				zero_s[j+1] <= zero_s[j];
				ovf_s[j+1]  <= ovf_s[j];
			end
		end

		if (j < DIV_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1]  <= take ? rem_s[j] - dsh : rem_s[j];
					magd_s[j+1] <= magd_s[j];
				end
			end
		end
	end

	assign q_ext = {1'b0, quo_s[DIV_STEPS]};

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (zero_s[DIV_STEPS]) begin
				quo_q <= '0;
			end else if (ovf_s[DIV_STEPS]) begin
				quo_q <= neg_s[DIV_STEPS] ? COORD_MIN : COORD_MAX;
			end else begin
				quo_q <= neg_s[DIV_STEPS] ? -q_ext : q_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS + 2; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= DIV_STEPS + 2; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[DIV_STEPS+2];
	assign quo       = quo_q;

endmodule

/* rtl/core/plane_plane_intersection.sv */
// Throughput: one plane pair per cycle while the output is not stalled; the 31-stage quotient pipeline sets depth.
// A stalled output freezes every stage together; nothing is dropped or repeated.
// Reset clears all stage valid bits and sets the parallel threshold to 1.
// ----------------------------------------------------------------------------
// Plane-plane intersection
// Line of intersection of two planes in Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
module plane_plane_intersection import ppi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata,
	ppi_in_if.sink           planes,
	ppi_out_if.source        result
);

	logic [THR_W-1:0] thr_q;
	logic             en;

	logic      v_front, v_numer, v_qa, v_qb;
	ppi_sel_t  sel;
	ppi_side_t side_front, side_numer;
	ppi_lane_t lane_a, lane_b;
	logic signed [COORD_W-1:0] qa, qb;
	ppi_side_t side_s [0:DIV_LAT-1];
	ppi_side_t side_o;

	assign en           = !result.valid || result.ready;
	assign planes.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	ppi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (planes.valid),
		.in_data   (planes.payload),
		.thr       (thr_q),
		.out_valid (v_front),
		.sel       (sel),
		.side      (side_front)
	);

	ppi_numer u_numer (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_front),
		.sel       (sel),
		.side_in   (side_front),
		.out_valid (v_numer),
		.lane_a    (lane_a),
		.lane_b    (lane_b),
		.side_out  (side_numer)
	);

	ppi_div u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_numer),
		.lane      (lane_a),
		.out_valid (v_qa),
		.quo       (qa)
	);

	ppi_div u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_numer),
		.lane      (lane_b),
		.out_valid (v_qb),
		.quo       (qb)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_numer;
			for (int k = 1; k < DIV_LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign side_o       = side_s[DIV_LAT-1];
	assign result.valid = v_qa & v_qb;

	always_comb begin
		result.payload.relation   = side_o.relation;
		result.payload.line_dir_x = side_o.dir_x;
		result.payload.line_dir_y = side_o.dir_y;
		result.payload.line_dir_z = side_o.dir_z;
		unique case (side_o.axis)
			AX_X: begin
				result.payload.line_point_x = '0;
				result.payload.line_point_y = qa;
				result.payload.line_point_z = qb;
			end
			AX_Y: begin
				result.payload.line_point_x = qa;
				result.payload.line_point_y = '0;
				result.payload.line_point_z = qb;
			end
			default: begin
				result.payload.line_point_x = qa;
				result.payload.line_point_y = qb;
				result.payload.line_point_z = '0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_parallel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.relation != REL_LINE |->
		result.payload.line_point_x == '0 && result.payload.line_point_y == '0 &&
		result.payload.line_point_z == '0)
		else $error("parallel result carries a nonzero line point");

	a_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.relation == REL_LINE |->
		result.payload.line_point_x == '0 || result.payload.line_point_y == '0 ||
		result.payload.line_point_z == '0)
		else $error("line point has no zeroed coordinate");

	a_line_dir: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.relation == REL_LINE |->
		result.payload.line_dir_x != '0 || result.payload.line_dir_y != '0 ||
		result.payload.line_dir_z != '0)
		else $error("intersecting result with zero direction");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		v_qa == v_qb)
		else $error("quotient lanes out of step");
`endif

endmodule
